/* rtl/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared constants and types for the pattern match counter: sizes of the
// pattern and failure memories, item codes and the structs that travel
// between the sequencer and the top level.
// ----------------------------------------------------------------------------
package kmp_pkg;

	// pattern capacity in bytes
	localparam int MAX_PATTERN = 256;

	// address of one pattern entry, and a length that can hold the capacity itself
	localparam int ADDR_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 24;

	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam len_t   MAX_LEN   = LEN_W'(MAX_PATTERN);
	localparam len_t   LEN_ONE   = LEN_W'(1);
	localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

	// item codes carried in func
	localparam logic FUNC_PATTERN = 1'b0;
	localparam logic FUNC_TEXT    = 1'b1;

	// one result beat
	typedef struct packed {
		logic   match;
		count_t count;
		logic   end_mark;
		logic   overflow;
	} res_t;

	// memory requests from the sequencer
	typedef struct packed {
		logic  pat_we;
		logic  fail_we;
		addr_t waddr;
		char_t pat_wdata;
		len_t  fail_wdata;
		addr_t pat_raddr;
		addr_t fail_raddr;
	} mem_req_t;

endpackage

/* rtl/kmp_in_if.sv */
// ----------------------------------------------------------------------------
// kmp_in_if
// Input channel: valid/ready handshake with one pattern or text byte a beat.
// ----------------------------------------------------------------------------
interface kmp_in_if;
	logic          valid;
	logic          ready;
	logic          func;
	kmp_pkg::char_t ch;
	logic          last;

	modport source (output valid, output func, output ch, output last, input ready);
	modport sink   (input valid, input func, input ch, input last, output ready);
endinterface

/* rtl/kmp_out_if.sv */
// ----------------------------------------------------------------------------
// kmp_out_if
// Output channel: valid/ready handshake with one result a beat.
// ----------------------------------------------------------------------------
interface kmp_out_if;
	logic            valid;
	logic            ready;
	logic            match;
	kmp_pkg::count_t count;
	logic            end_mark;
	logic            overflow;

	modport source (output valid, output match, output count, output end_mark,
		output overflow, input ready);
	modport sink   (input valid, input match, input count, input end_mark,
		input overflow, output ready);
endinterface

/* rtl/kmp_ram.sv */
// ----------------------------------------------------------------------------
// kmp_ram
// Generic single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
module kmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/kmp_seq.sv */
// ----------------------------------------------------------------------------
// kmp_seq
// Match sequencer: takes one byte, walks failure links through the pattern
// and failure memories, appends pattern bytes with their failure entry and
// keeps the matched length and the occurrence count.
// ----------------------------------------------------------------------------
module kmp_seq (
	input  logic              clk,
	input  logic              arst_n,
	kmp_in_if.sink            req,
	output kmp_pkg::res_t     res,
	output logic              res_valid,
	input  logic              out_free,
	output kmp_pkg::mem_req_t mem,
	input  kmp_pkg::char_t    pat_rdata,
	input  kmp_pkg::len_t     fail_rdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FAIL,
		ST_CMP,
		ST_BACK,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic            func_q;
	kmp_pkg::char_t  ch_q;
	logic            last_q;
	logic            hit_q;
	logic            ovf_q;
	logic            closed_q;
	kmp_pkg::len_t   len_q;
	kmp_pkg::len_t   bnd_q;
	kmp_pkg::len_t   j_q;
	kmp_pkg::len_t   ml_q;
	kmp_pkg::count_t cnt_q;

	kmp_pkg::len_t eff_len;
	kmp_pkg::len_t j_start;
	kmp_pkg::len_t jf;
	kmp_pkg::len_t jn;
	logic          eq;
	logic          mis;

	// start values for an incoming beat, and the failure-link and compare values
	always_comb begin
		eff_len = closed_q ? '0 : len_q;
		j_start = (ml_q >= len_q) ? '0 : ml_q;
		jf      = (fail_rdata >= bnd_q) ? '0 : fail_rdata;
		eq      = (ch_q == pat_rdata);
		mis     = (j_q != '0) && !eq;
		jn      = j_q + kmp_pkg::len_t'(eq);
	end

	// memory reads and writes by state
	always_comb begin
		mem            = '0;
		mem.pat_raddr  = j_q[kmp_pkg::ADDR_W-1:0];
		mem.fail_raddr = j_q[kmp_pkg::ADDR_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (req.func == kmp_pkg::FUNC_PATTERN) begin
					mem.fail_raddr = kmp_pkg::ADDR_W'(eff_len - kmp_pkg::LEN_ONE);
					// first pattern byte goes straight in with failure zero
					if (req.valid && eff_len == '0) begin
						mem.pat_we    = 1'b1;
						mem.fail_we   = 1'b1;
						mem.waddr     = '0;
						mem.pat_wdata = req.ch;
					end
				end else begin
					mem.pat_raddr = j_start[kmp_pkg::ADDR_W-1:0];
				end
			end
			ST_FAIL: begin
				mem.pat_raddr = jf[kmp_pkg::ADDR_W-1:0];
			end
			ST_CMP: begin
				if (mis) begin
					mem.fail_raddr = kmp_pkg::ADDR_W'(j_q - kmp_pkg::LEN_ONE);
				end else if (func_q == kmp_pkg::FUNC_PATTERN) begin
					mem.pat_we     = 1'b1;
					mem.fail_we    = 1'b1;
					mem.waddr      = bnd_q[kmp_pkg::ADDR_W-1:0];
					mem.pat_wdata  = ch_q;
					mem.fail_wdata = jn;
				end else begin
					mem.fail_raddr = kmp_pkg::ADDR_W'(len_q - kmp_pkg::LEN_ONE);
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready    = (state_q == ST_IDLE);
	assign res_valid    = (state_q == ST_DONE);
	assign res.match    = hit_q;
	assign res.count    = cnt_q;
	assign res.end_mark = last_q;
	assign res.overflow = ovf_q;

	// sequencer state and match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			closed_q <= 1'b1;
			len_q    <= '0;
			ml_q     <= '0;
			cnt_q    <= '0;
			hit_q    <= 1'b0;
			ovf_q    <= 1'b0;
			last_q   <= 1'b0;
			func_q   <= kmp_pkg::FUNC_PATTERN;
			ch_q     <= '0;
			bnd_q    <= '0;
			j_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						func_q <= req.func;
						ch_q   <= req.ch;
						last_q <= req.last;
						hit_q  <= 1'b0;
						if (req.func == kmp_pkg::FUNC_PATTERN) begin
							// a closed pattern is replaced by a new one
							closed_q <= 1'b0;
							if (closed_q) begin
								ml_q <= '0;
							end
							len_q <= (eff_len == '0) ? kmp_pkg::LEN_ONE : eff_len;
							bnd_q <= eff_len;
							ovf_q <= (eff_len == kmp_pkg::MAX_LEN);
							if (eff_len == kmp_pkg::MAX_LEN) begin
								state_q <= ST_DONE;
							end else if (eff_len == '0) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_FAIL;
							end
						end else begin
							ovf_q    <= 1'b0;
							closed_q <= 1'b1;
							bnd_q    <= len_q;
							j_q      <= j_start;
							if (len_q == '0) begin
								ml_q    <= '0;
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_CMP;
							end
						end
					end
				end
				ST_FAIL: begin
					j_q     <= jf;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (mis) begin
						state_q <= ST_FAIL;
					end else if (func_q == kmp_pkg::FUNC_PATTERN) begin
						len_q   <= bnd_q + kmp_pkg::LEN_ONE;
						state_q <= ST_DONE;
					end else if (jn == bnd_q) begin
						// full occurrence, fall back to the last failure entry
						hit_q <= 1'b1;
						if (cnt_q != kmp_pkg::COUNT_MAX) begin
							cnt_q <= cnt_q + kmp_pkg::count_t'(1);
						end
						state_q <= ST_BACK;
					end else begin
						ml_q    <= jn;
						state_q <= ST_DONE;
					end
				end
				ST_BACK: begin
					ml_q    <= fail_rdata;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						if (last_q) begin
							if (func_q == kmp_pkg::FUNC_TEXT) begin
								ml_q  <= '0;
								cnt_q <= '0;
							end else begin
								closed_q <= 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/kmp_pattern_match_counter.sv */
// ----------------------------------------------------------------------------
// kmp_pattern_match_counter
// Counts pattern occurrences in a text, overlapping ones included, with
// Knuth-Morris-Pratt matching over a pattern memory and a failure memory.
// ----------------------------------------------------------------------------
//  channel  dir  payload                            beat
//  req      in   func, ch, last                     one pattern or text byte
//  rsp      out  match, count, end_mark, overflow   one result per req beat
//
// one byte at a time: accept, then per extra compare step of the failure-link
// walk a failure memory read then a pattern memory read, a fallback after a
// full match and a handover of the result. a text byte that matches at once
// is accepted, compared and handed over, a pattern byte reads its failure
// entry first; the first pattern byte, a dropped one and empty-pattern text
// go straight to handover. the result shows on rsp the cycle after handover.
// the memories need no clearing after reset; only written entries are read.
// a result waiting in the output register holds the sequencer in its last
// state; the next byte is taken once the result has moved there.
module kmp_pattern_match_counter (
	input  logic      clk,
	input  logic      arst_n,
	kmp_in_if.sink    req,
	kmp_out_if.source rsp
);

	kmp_pkg::res_t     res;
	logic              res_valid;
	logic              out_free;
	kmp_pkg::mem_req_t mem;
	kmp_pkg::char_t    pat_rdata;
	kmp_pkg::len_t     fail_rdata;
	logic              vld_q;
	kmp_pkg::res_t     out_q;

	kmp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.out_free  (out_free),
		.mem       (mem),
		.pat_rdata (pat_rdata),
		.fail_rdata(fail_rdata)
	);

	// pattern bytes
	kmp_ram #(
		.WIDTH(kmp_pkg::CHAR_W),
		.DEPTH(kmp_pkg::MAX_PATTERN)
	) u_pat_ram (
		.clk  (clk),
		.we   (mem.pat_we),
		.waddr(mem.waddr),
		.wdata(mem.pat_wdata),
		.raddr(mem.pat_raddr),
		.rdata(pat_rdata)
	);

	// failure entries
	kmp_ram #(
		.WIDTH(kmp_pkg::LEN_W),
		.DEPTH(kmp_pkg::MAX_PATTERN)
	) u_fail_ram (
		.clk  (clk),
		.we   (mem.fail_we),
		.waddr(mem.waddr),
		.wdata(mem.fail_wdata),
		.raddr(mem.fail_raddr),
		.rdata(fail_rdata)
	);

	// output register
	assign out_free = !vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (out_free) begin
			vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid    = vld_q;
	assign rsp.match    = out_q.match;
	assign rsp.count    = out_q.count;
	assign rsp.end_mark = out_q.end_mark;
	assign rsp.overflow = out_q.overflow;

	// a match always leaves a nonzero count
	a_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.match |-> rsp.count != '0)
		else $error("match reported with zero count");

	// a match and an overflow never come from the same byte
	a_match_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.match && rsp.overflow))
		else $error("match and overflow in one result");

	// one byte in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second byte accepted while one is in work");

	// memories are never written while a result waits for the output register
	a_no_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !mem.pat_we && !mem.fail_we)
		else $error("memory write while result pending");

endmodule
